FILE: rtl/idsc_pkg.sv
// shared constants, command codes, status struct and permutation helpers
// for the incremental difference set checker; no dependencies
`timescale 1ns / 1ps

package idsc_pkg;

  localparam int unsigned MAX_ORDER  = 64;
  localparam int unsigned MAX_POINTS = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_ORDER);
  localparam int unsigned ORD_W      = IDX_W + 1;
  localparam int unsigned PERM_W     = 4 * MAX_POINTS;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned DEG_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP    = 3'd3;
  localparam logic [OP_W-1:0] OP_FINISH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAMBDA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MU          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ORDER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE      = 3'd4;

  localparam logic [1:0] MODE_DS  = 2'd0;
  localparam logic [1:0] MODE_PDS = 2'd1;
  localparam logic [1:0] MODE_RDS = 2'd2;

  typedef enum logic [5:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_LOAD,
    CMD_MARK,
    CMD_LK_PERM,
    CMD_LK_ID,
    CMD_LK_Q1,
    CMD_LK_Q2,
    CMD_LK_INV,
    CMD_CS_START,
    CMD_LK_STEP,
    CMD_CS_STEP,
    CMD_X_SAVE,
    CMD_ID_SAVE,
    CMD_PUSH_BAD,
    CMD_AQ_INIT,
    CMD_AQ_XP,
    CMD_K_INC,
    CMD_RD_STACK,
    CMD_RD_Y,
    CMD_Y_INV,
    CMD_MAKE_Q,
    CMD_CNT_RD,
    CMD_CNT_WR,
    CMD_PUSH_COMMIT,
    CMD_EV_INIT,
    CMD_EV_CHK,
    CMD_EV_DONE,
    CMD_RD_TOP,
    CMD_POP_SETX,
    CMD_POP_END,
    CMD_EMIT
  } idsc_cmd_e;

  typedef struct packed {
    logic            look_done;
    logic            hit;
    logic            k_end;
    logic            k_active;
    logic            top_active;
    logic            depth_zero;
    logic            depth_full;
    logic            xhit;
    logic            mode_pds;
    logic [OP_W-1:0] op;
  } idsc_stat_t;

  function automatic logic [PERM_W-1:0] perm_mask(input logic [DEG_W-1:0] n);
    logic [PERM_W-1:0] m;
    m = '0;
    for (int j = 0; j < MAX_POINTS; j++) begin
      if (DEG_W'(j) < n) m[4*j +: 4] = 4'hf;
    end
    return m;
  endfunction

  function automatic logic [PERM_W-1:0] perm_identity();
    logic [PERM_W-1:0] r;
    for (int i = 0; i < MAX_POINTS; i++) r[4*i +: 4] = 4'(i);
    return r;
  endfunction

  // unset images land on point zero, later points win
  function automatic logic [PERM_W-1:0] perm_invert(input logic [PERM_W-1:0] p,
                                                    input logic [DEG_W-1:0] n);
    logic [3:0] inv [MAX_POINTS];
    logic [PERM_W-1:0] r;
    r = '0;
    for (int j = 0; j < MAX_POINTS; j++) inv[j] = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (DEG_W'(i) < n) inv[p[4*i +: 4]] = 4'(i);
    end
    for (int j = 0; j < MAX_POINTS; j++) begin
      if (DEG_W'(j) < n) r[4*j +: 4] = inv[j];
    end
    return r;
  endfunction

  // result point i is a applied to yi applied to i
  function automatic logic [PERM_W-1:0] perm_compose(input logic [PERM_W-1:0] a,
                                                     input logic [PERM_W-1:0] yi,
                                                     input logic [DEG_W-1:0] n);
    logic [PERM_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (DEG_W'(i) < n) r[4*i +: 4] = a[4*yi[4*i +: 4] +: 4];
    end
    return r;
  endfunction

endpackage

FILE: rtl/idsc_in_if.sv
// input channel: opcode, permutation and slot with valid/ready
// depends on idsc_pkg
`timescale 1ns / 1ps

interface idsc_in_if import idsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [PERM_W-1:0]   permutation;
  logic [IDX_W-1:0]    element_slot;

  modport source (output valid, opcode, permutation, element_slot, input ready);
  modport sink (input valid, opcode, permutation, element_slot, output ready);
endinterface

FILE: rtl/idsc_out_if.sv
// result channel: index, flags and verdict with valid/ready
// depends on idsc_pkg
`timescale 1ns / 1ps

interface idsc_out_if import idsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ORD_W-1:0] hit_index;
  logic             found;
  logic             still_possible;
  logic             verdict;
  logic             bad_row_seen;

  modport source (output valid, hit_index, found, still_possible, verdict, bad_row_seen,
                  input ready);
  modport sink (input valid, hit_index, found, still_possible, verdict, bad_row_seen,
                output ready);
endinterface

FILE: rtl/idsc_dp.sv
// datapath: config registers, element store, stack, difference counts,
// scan unit and result registers; depends on idsc_pkg
`timescale 1ns / 1ps

module idsc_dp import idsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  idsc_cmd_e             cmd_i,
  output idsc_stat_t            stat_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [PERM_W-1:0]     permutation_i,
  input  logic [IDX_W-1:0]      element_slot_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [ORD_W-1:0]      hit_index_o,
  output logic                  found_o,
  output logic                  still_possible_o,
  output logic                  verdict_o,
  output logic                  bad_row_seen_o
);

  logic [1:0]        mode_q;
  logic [CNT_W-1:0]  lambda_q, mu_q;
  logic [ORD_W-1:0]  order_q;
  logic [DEG_W-1:0]  degree_q;

  logic [OP_W-1:0]   op_q;
  logic [PERM_W-1:0] perm_q;
  logic [IDX_W-1:0]  slot_q;

  logic [PERM_W-1:0] store_mem [MAX_ORDER];
  logic [PERM_W-1:0] st_rd_q;
  logic [IDX_W-1:0]  stack_mem [MAX_ORDER];
  logic [IDX_W-1:0]  sk_rd_q;
  logic [CNT_W-1:0]  cnt_mem [MAX_ORDER];
  logic [CNT_W-1:0]  cnt_rd_q;
  logic [IDX_W-1:0]  cnt_ra_q;

  logic [MAX_ORDER-1:0] active_q, chosen_q, forb_q, cnt_vld_q;
  logic [ORD_W-1:0]  depth_q, id_q;
  logic              bad_q;

  logic [IDX_W-1:0]  x_q;
  logic              xhit_q;
  logic [PERM_W-1:0] xperm_q, xinv_q, yperm_q, yinv_q, q1_q, q2_q, target_q;
  logic [ORD_W-1:0]  idx_q, k_q, upto_q;
  logic              prev_vld_q, hit_q, dec_q, fail_q;
  logic [IDX_W-1:0]  prev_idx_q, hit_idx_q;

  logic [ORD_W-1:0]  res_idx_q;
  logic              res_found_q, res_poss_q, res_verd_q;
  logic [ORD_W-1:0]  out_idx_q;
  logic              out_found_q, out_poss_q, out_verd_q, out_bad_q;

  logic [ORD_W-1:0]  v;
  logic [DEG_W-1:0]  n;
  logic [PERM_W-1:0] mask;
  logic              pds, rds, scan_rd, match;
  logic [ORD_W-1:0]  depth_m1;
  logic [IDX_W-1:0]  top_idx;
  logic [CNT_W-1:0]  cnt_val, cnt_next, und, lim, want;
  logic              cnt_bad, cs_fail, ev_fail;

  logic              st_we, st_re, sk_we, sk_re, cn_we, cn_re;
  logic [IDX_W-1:0]  st_ra, sk_ra, sk_wd, cn_ra;

  assign v        = (order_q > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : order_q;
  assign n        = (degree_q > DEG_W'(MAX_POINTS)) ? DEG_W'(MAX_POINTS) : degree_q;
  assign mask     = perm_mask(n);
  assign pds      = (mode_q == MODE_PDS);
  assign rds      = (mode_q == MODE_RDS);
  assign scan_rd  = (idx_q < v);
  assign match    = ((st_rd_q ^ target_q) & mask) == '0;
  assign depth_m1 = depth_q - ORD_W'(1);
  assign top_idx  = depth_m1[IDX_W-1:0];
  assign cnt_val  = cnt_vld_q[cnt_ra_q] ? cnt_rd_q : '0;
  assign cnt_next = dec_q ? cnt_val - CNT_W'(1) : cnt_val + CNT_W'(1);
  assign und      = (lambda_q > mu_q) ? lambda_q : mu_q;

  // count check for the entry read on the previous scan cycle
  always_comb begin
    lim  = lambda_q;
    want = lambda_q;
    if (op_q == OP_FINISH) begin
      if (pds) begin
        want = chosen_q[prev_idx_q] ? lambda_q : mu_q;
      end else if (rds && forb_q[prev_idx_q]) begin
        want = '0;
      end
      cnt_bad = (cnt_val != want);
    end else begin
      if (pds) begin
        if (chosen_q[prev_idx_q]) lim = lambda_q;
        else if (prev_idx_q < x_q) lim = mu_q;
        else lim = und;
        cnt_bad = (cnt_val > lim);
      end else if (rds && forb_q[prev_idx_q]) begin
        cnt_bad = (cnt_val != '0);
      end else begin
        cnt_bad = (cnt_val > lambda_q);
      end
    end
  end

  assign cs_fail = prev_vld_q && ({1'b0, prev_idx_q} != id_q) && cnt_bad;
  assign ev_fail = (op_q == OP_FINISH) ? (!hit_q || !chosen_q[hit_idx_q])
                                       : (hit_q && (hit_idx_q < x_q) && !chosen_q[hit_idx_q]);

  always_comb begin
    st_we = 1'b0;
    st_re = 1'b0;
    st_ra = x_q;
    sk_we = 1'b0;
    sk_re = 1'b0;
    sk_ra = k_q[IDX_W-1:0];
    sk_wd = x_q;
    cn_we = 1'b0;
    cn_re = 1'b0;
    cn_ra = hit_idx_q;
    case (cmd_i)
      CMD_LOAD:        st_we = (depth_q == '0);
      CMD_LK_STEP,
      CMD_CS_STEP: begin
        st_re = scan_rd;
        cn_re = scan_rd;
        st_ra = idx_q[IDX_W-1:0];
        cn_ra = idx_q[IDX_W-1:0];
      end
      CMD_AQ_INIT:     st_re = 1'b1;
      CMD_RD_Y: begin
        st_re = 1'b1;
        st_ra = sk_rd_q;
      end
      CMD_RD_STACK:    sk_re = 1'b1;
      CMD_RD_TOP: begin
        sk_re = 1'b1;
        sk_ra = top_idx;
      end
      CMD_PUSH_BAD: begin
        sk_we = 1'b1;
        sk_wd = '0;
      end
      CMD_PUSH_COMMIT: sk_we = 1'b1;
      CMD_CNT_RD:      cn_re = 1'b1;
      CMD_CNT_WR:      cn_we = hit_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[slot_q] <= perm_q;
    if (st_re) st_rd_q <= store_mem[st_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sk_we) stack_mem[depth_q[IDX_W-1:0]] <= sk_wd;
    if (sk_re) sk_rd_q <= stack_mem[sk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cn_we) cnt_mem[hit_idx_q] <= cnt_next;
    if (cn_re) begin
      cnt_rd_q <= cnt_mem[cn_ra];
      cnt_ra_q <= cn_ra;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_DS;
      lambda_q    <= '0;
      mu_q        <= '0;
      order_q     <= ORD_W'(MAX_ORDER);
      degree_q    <= DEG_W'(MAX_POINTS);
      op_q        <= OP_LOAD;
      perm_q      <= '0;
      slot_q      <= '0;
      active_q    <= '0;
      chosen_q    <= '0;
      forb_q      <= '0;
      cnt_vld_q   <= '0;
      depth_q     <= '0;
      id_q        <= ORD_W'(MAX_ORDER);
      bad_q       <= 1'b0;
      x_q         <= '0;
      xhit_q      <= 1'b0;
      xperm_q     <= '0;
      xinv_q      <= '0;
      yperm_q     <= '0;
      yinv_q      <= '0;
      q1_q        <= '0;
      q2_q        <= '0;
      target_q    <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      upto_q      <= '0;
      prev_vld_q  <= 1'b0;
      prev_idx_q  <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      dec_q       <= 1'b0;
      fail_q      <= 1'b0;
      res_idx_q   <= '0;
      res_found_q <= 1'b0;
      res_poss_q  <= 1'b0;
      res_verd_q  <= 1'b0;
      out_idx_q   <= '0;
      out_found_q <= 1'b0;
      out_poss_q  <= 1'b0;
      out_verd_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CHECK_MODE:  mode_q   <= cfg_data_i[1:0];
          REG_LAMBDA:      lambda_q <= cfg_data_i;
          REG_MU:          mu_q     <= cfg_data_i;
          REG_GROUP_ORDER: order_q  <= cfg_data_i;
          REG_DEGREE:      degree_q <= cfg_data_i[DEG_W-1:0];
          default: ;
        endcase
      end
      case (cmd_i)
        CMD_ACCEPT: begin
          op_q        <= opcode_i;
          perm_q      <= permutation_i;
          slot_q      <= element_slot_i;
          res_idx_q   <= '0;
          res_found_q <= 1'b0;
          res_poss_q  <= 1'b0;
          res_verd_q  <= 1'b0;
        end
        CMD_MARK:  forb_q[slot_q] <= 1'b1;
        CMD_LK_PERM, CMD_LK_ID, CMD_LK_Q1, CMD_LK_Q2, CMD_LK_INV, CMD_CS_START: begin
          idx_q      <= '0;
          prev_vld_q <= 1'b0;
          hit_q      <= 1'b0;
          case (cmd_i)
            CMD_LK_PERM: target_q <= perm_q;
            CMD_LK_ID:   target_q <= perm_identity();
            CMD_LK_Q1:   target_q <= q1_q;
            CMD_LK_Q2:   target_q <= q2_q;
            CMD_LK_INV:  target_q <= perm_invert(st_rd_q, n);
            default: ;
          endcase
        end
        CMD_LK_STEP, CMD_CS_STEP: begin
          idx_q      <= idx_q + ORD_W'(scan_rd);
          prev_vld_q <= scan_rd;
          prev_idx_q <= idx_q[IDX_W-1:0];
          if (cmd_i == CMD_LK_STEP) begin
            if (prev_vld_q && !hit_q && match) begin
              hit_q     <= 1'b1;
              hit_idx_q <= prev_idx_q;
            end
          end else if (cs_fail) begin
            fail_q <= 1'b1;
          end
        end
        CMD_X_SAVE: begin
          xhit_q      <= hit_q;
          x_q         <= hit_idx_q;
          res_idx_q   <= hit_q ? {1'b0, hit_idx_q} : v;
          res_found_q <= hit_q;
        end
        CMD_ID_SAVE: id_q <= hit_q ? {1'b0, hit_idx_q} : ORD_W'(MAX_ORDER);
        CMD_PUSH_BAD: begin
          bad_q                        <= 1'b1;
          active_q[depth_q[IDX_W-1:0]] <= 1'b0;
          depth_q                      <= depth_q + ORD_W'(1);
        end
        CMD_AQ_INIT: begin
          k_q    <= '0;
          upto_q <= (op_q == OP_POP) ? depth_m1 : depth_q;
          dec_q  <= (op_q == OP_POP);
        end
        CMD_AQ_XP: begin
          xperm_q <= st_rd_q;
          xinv_q  <= perm_invert(st_rd_q, n);
        end
        CMD_K_INC: k_q <= k_q + ORD_W'(1);
        CMD_Y_INV: begin
          yperm_q <= st_rd_q;
          yinv_q  <= perm_invert(st_rd_q, n);
        end
        CMD_MAKE_Q: begin
          q1_q <= perm_compose(xperm_q, yinv_q, n);
          q2_q <= perm_compose(yperm_q, xinv_q, n);
        end
        CMD_CNT_WR: if (hit_q) cnt_vld_q[hit_idx_q] <= 1'b1;
        CMD_PUSH_COMMIT: begin
          active_q[depth_q[IDX_W-1:0]] <= 1'b1;
          chosen_q[x_q]                <= 1'b1;
          depth_q                      <= depth_q + ORD_W'(1);
        end
        CMD_EV_INIT: begin
          k_q    <= '0;
          upto_q <= depth_q;
          fail_q <= pds && (id_q < v) && chosen_q[id_q[IDX_W-1:0]];
        end
        CMD_EV_CHK: if (ev_fail) fail_q <= 1'b1;
        CMD_EV_DONE: begin
          if (op_q == OP_FINISH) res_verd_q <= !fail_q;
          else res_poss_q <= !fail_q;
        end
        CMD_POP_SETX: x_q <= sk_rd_q;
        CMD_POP_END: begin
          if (active_q[top_idx]) chosen_q[x_q] <= 1'b0;
          active_q[top_idx] <= 1'b0;
          depth_q           <= depth_m1;
        end
        CMD_EMIT: begin
          out_idx_q   <= res_idx_q;
          out_found_q <= res_found_q;
          out_poss_q  <= res_poss_q;
          out_verd_q  <= res_verd_q;
          out_bad_q   <= bad_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.look_done  = (idx_q >= v) && !prev_vld_q;
    stat_o.hit        = hit_q;
    stat_o.k_end      = (k_q >= upto_q);
    stat_o.k_active   = active_q[k_q[IDX_W-1:0]];
    stat_o.top_active = active_q[top_idx];
    stat_o.depth_zero = (depth_q == '0);
    stat_o.depth_full = (depth_q == ORD_W'(MAX_ORDER));
    stat_o.xhit       = xhit_q;
    stat_o.mode_pds   = pds;
    stat_o.op         = op_q;
  end

  assign hit_index_o      = out_idx_q;
  assign found_o          = out_found_q;
  assign still_possible_o = out_poss_q;
  assign verdict_o        = out_verd_q;
  assign bad_row_seen_o   = out_bad_q;

endmodule

FILE: rtl/idsc_ctrl.sv
// controller: sequences lookups, quotient updates and checks per opcode
// depends on idsc_pkg
`timescale 1ns / 1ps

module idsc_ctrl import idsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  idsc_stat_t stat_i,
  output idsc_cmd_e  cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_PLOOK   = 5'd2;
  localparam logic [4:0] S_IDSTART = 5'd3;
  localparam logic [4:0] S_IDLOOK  = 5'd4;
  localparam logic [4:0] S_PBAD    = 5'd5;
  localparam logic [4:0] S_AQINIT  = 5'd6;
  localparam logic [4:0] S_AQXP    = 5'd7;
  localparam logic [4:0] S_AQK     = 5'd8;
  localparam logic [4:0] S_AQY     = 5'd9;
  localparam logic [4:0] S_AQYI    = 5'd10;
  localparam logic [4:0] S_AQQ     = 5'd11;
  localparam logic [4:0] S_AQL1S   = 5'd12;
  localparam logic [4:0] S_AQL1    = 5'd13;
  localparam logic [4:0] S_AQW1    = 5'd14;
  localparam logic [4:0] S_AQL2S   = 5'd15;
  localparam logic [4:0] S_AQL2    = 5'd16;
  localparam logic [4:0] S_AQW2    = 5'd17;
  localparam logic [4:0] S_AQNX    = 5'd18;
  localparam logic [4:0] S_POPCHK  = 5'd19;
  localparam logic [4:0] S_EVINIT  = 5'd20;
  localparam logic [4:0] S_EVK     = 5'd21;
  localparam logic [4:0] S_EVY     = 5'd22;
  localparam logic [4:0] S_EVI     = 5'd23;
  localparam logic [4:0] S_EVL     = 5'd24;
  localparam logic [4:0] S_EVNX    = 5'd25;
  localparam logic [4:0] S_CSS     = 5'd26;
  localparam logic [4:0] S_CSL     = 5'd27;
  localparam logic [4:0] S_FIN     = 5'd28;

  logic [4:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d   = state_q;
    cmd_o     = CMD_NONE;
    out_vld_d = out_vld_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_ACCEPT;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.op)
          OP_LOAD: begin
            cmd_o   = CMD_LOAD;
            state_d = S_FIN;
          end
          OP_MARK: begin
            cmd_o   = CMD_MARK;
            state_d = S_FIN;
          end
          OP_PUSH: begin
            cmd_o   = CMD_LK_PERM;
            state_d = S_PLOOK;
          end
          OP_POP: begin
            if (stat_i.depth_zero) begin
              state_d = S_FIN;
            end else begin
              cmd_o   = CMD_RD_TOP;
              state_d = S_POPCHK;
            end
          end
          OP_FINISH: begin
            cmd_o   = CMD_LK_ID;
            state_d = S_IDLOOK;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_PLOOK: begin
        if (!stat_i.look_done) begin
          cmd_o = CMD_LK_STEP;
        end else begin
          cmd_o   = CMD_X_SAVE;
          state_d = S_IDSTART;
        end
      end
      S_IDSTART: begin
        cmd_o   = CMD_LK_ID;
        state_d = S_IDLOOK;
      end
      S_IDLOOK: begin
        if (!stat_i.look_done) begin
          cmd_o = CMD_LK_STEP;
        end else begin
          cmd_o = CMD_ID_SAVE;
          if (stat_i.op == OP_FINISH) state_d = S_EVINIT;
          else if (stat_i.depth_full) state_d = S_FIN;
          else if (!stat_i.xhit) state_d = S_PBAD;
          else state_d = S_AQINIT;
        end
      end
      S_PBAD: begin
        cmd_o   = CMD_PUSH_BAD;
        state_d = S_FIN;
      end
      S_AQINIT: begin
        cmd_o   = CMD_AQ_INIT;
        state_d = S_AQXP;
      end
      S_AQXP: begin
        cmd_o   = CMD_AQ_XP;
        state_d = S_AQK;
      end
      S_AQK: begin
        if (stat_i.k_end) begin
          if (stat_i.op == OP_PUSH) begin
            cmd_o   = CMD_PUSH_COMMIT;
            state_d = S_EVINIT;
          end else begin
            cmd_o   = CMD_POP_END;
            state_d = S_FIN;
          end
        end else if (!stat_i.k_active) begin
          cmd_o = CMD_K_INC;
        end else begin
          cmd_o   = CMD_RD_STACK;
          state_d = S_AQY;
        end
      end
      S_AQY: begin
        cmd_o   = CMD_RD_Y;
        state_d = S_AQYI;
      end
      S_AQYI: begin
        cmd_o   = CMD_Y_INV;
        state_d = S_AQQ;
      end
      S_AQQ: begin
        cmd_o   = CMD_MAKE_Q;
        state_d = S_AQL1S;
      end
      S_AQL1S: begin
        cmd_o   = CMD_LK_Q1;
        state_d = S_AQL1;
      end
      S_AQL1: begin
        if (!stat_i.look_done) begin
          cmd_o = CMD_LK_STEP;
        end else begin
          cmd_o   = CMD_CNT_RD;
          state_d = S_AQW1;
        end
      end
      S_AQW1: begin
        cmd_o   = CMD_CNT_WR;
        state_d = S_AQL2S;
      end
      S_AQL2S: begin
        cmd_o   = CMD_LK_Q2;
        state_d = S_AQL2;
      end
      S_AQL2: begin
        if (!stat_i.look_done) begin
          cmd_o = CMD_LK_STEP;
        end else begin
          cmd_o   = CMD_CNT_RD;
          state_d = S_AQW2;
        end
      end
      S_AQW2: begin
        cmd_o   = CMD_CNT_WR;
        state_d = S_AQNX;
      end
      S_AQNX: begin
        cmd_o   = CMD_K_INC;
        state_d = S_AQK;
      end
      S_POPCHK: begin
        if (stat_i.top_active) begin
          cmd_o   = CMD_POP_SETX;
          state_d = S_AQINIT;
        end else begin
          cmd_o   = CMD_POP_END;
          state_d = S_FIN;
        end
      end
      S_EVINIT: begin
        cmd_o   = CMD_EV_INIT;
        state_d = stat_i.mode_pds ? S_EVK : S_CSS;
      end
      S_EVK: begin
        if (stat_i.k_end) begin
          state_d = S_CSS;
        end else if (!stat_i.k_active) begin
          cmd_o = CMD_K_INC;
        end else begin
          cmd_o   = CMD_RD_STACK;
          state_d = S_EVY;
        end
      end
      S_EVY: begin
        cmd_o   = CMD_RD_Y;
        state_d = S_EVI;
      end
      S_EVI: begin
        cmd_o   = CMD_LK_INV;
        state_d = S_EVL;
      end
      S_EVL: begin
        if (!stat_i.look_done) begin
          cmd_o = CMD_LK_STEP;
        end else begin
          cmd_o   = CMD_EV_CHK;
          state_d = S_EVNX;
        end
      end
      S_EVNX: begin
        cmd_o   = CMD_K_INC;
        state_d = S_EVK;
      end
      S_CSS: begin
        cmd_o   = CMD_CS_START;
        state_d = S_CSL;
      end
      S_CSL: begin
        if (!stat_i.look_done) begin
          cmd_o = CMD_CS_STEP;
        end else begin
          cmd_o   = CMD_EV_DONE;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o     = CMD_EMIT;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

FILE: rtl/incremental_difference_set_checker_unit.sv
// Difference set checker over a loaded permutation group. Items are taken one at a time and
// each gives one result. Load, mark, an ignored pop and an undefined opcode go straight to
// the result. Every lookup scans the element store through its single read port, one
// entry a cycle. A push looks up its permutation and the identity, then, for each active
// stack entry below it, looks up both quotients and updates their counts, then scans the
// counts; partial difference set mode adds a lookup for each active entry after the push.
// A push on a full stack makes only the two lookups. A pop of an active entry updates the
// counts for each active entry below it. A finish looks up the identity, adds in partial
// mode a lookup for each active entry and scans the counts. A result waiting on the output
// holds the controller in its last state; the next item is taken while a finished result
// waits in the output register.
// top level: joins idsc_ctrl and idsc_dp; depends on idsc_pkg and the channel interfaces
`timescale 1ns / 1ps

module incremental_difference_set_checker_unit import idsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  idsc_in_if.sink               req_i,
  idsc_out_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  idsc_cmd_e  cmd;
  idsc_stat_t stat;

  idsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  idsc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .opcode_i         (req_i.opcode),
    .permutation_i    (req_i.permutation),
    .element_slot_i   (req_i.element_slot),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .hit_index_o      (rsp_o.hit_index),
    .found_o          (rsp_o.found),
    .still_possible_o (rsp_o.still_possible),
    .verdict_o        (rsp_o.verdict),
    .bad_row_seen_o   (rsp_o.bad_row_seen)
  );

  // one item in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("input taken while an item is in flight");

  // never push past a full stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_PUSH_COMMIT) |-> !stat.depth_full)
    else $error("push commit on full stack");

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_EMIT) |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result register overwritten");

endmodule

FILE: test/incremental_difference_set_checker_unit_test.sv
// self-checking bench for incremental_difference_set_checker_unit: table-driven directed
// items, then random group phases checked against an in-bench difference count predictor
// depends on idsc_pkg, idsc_in_if, idsc_out_if and the rtl top level
`timescale 1ns / 1ps

module incremental_difference_set_checker_unit_test;
  import idsc_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned STACK_CAP = 10;

  typedef struct packed {
    logic [ORD_W-1:0] index;
    logic             found;
    logic             possible;
    logic             verdict;
    logic             bad;
  } result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [PERM_W-1:0] perm;
    logic [IDX_W-1:0]  slot;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  idsc_in_if req ();
  idsc_out_if rsp ();

  incremental_difference_set_checker_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [PERM_W-1:0] rows [MAX_ORDER];
  bit                forbidden [MAX_ORDER];
  logic [CNT_W-1:0]  diff_cnt [MAX_ORDER];
  bit                chosen [MAX_ORDER];
  logic [IDX_W-1:0]  stk [MAX_ORDER];
  bit                stk_on [MAX_ORDER];
  int unsigned depth, id_idx;
  bit bad_flag;
  int unsigned mode_r, lam_r, mu_r, order_r, deg_r;

  result_t pending_results[$];
  int unsigned items_sent, errors;
  int unsigned in_idle, out_idle;

  function automatic int unsigned eff_order();
    return order_r > MAX_ORDER ? MAX_ORDER : order_r;
  endfunction

  function automatic int unsigned eff_deg();
    return deg_r > MAX_POINTS ? MAX_POINTS : deg_r;
  endfunction

  function automatic logic [PERM_W-1:0] deg_mask(input int unsigned n);
    logic [PERM_W-1:0] m;
    m = '0;
    for (int j = 0; j < MAX_POINTS; j++) if (j < n) m[4*j +: 4] = 4'hf;
    return m;
  endfunction

  function automatic int unsigned find_row(input logic [PERM_W-1:0] p);
    logic [PERM_W-1:0] m;
    m = deg_mask(eff_deg());
    for (int unsigned g = 0; g < eff_order(); g++) if (((rows[g] ^ p) & m) == '0) return g;
    return eff_order();
  endfunction

  function automatic logic [PERM_W-1:0] inv_perm(input logic [PERM_W-1:0] p);
    logic [3:0] inv [MAX_POINTS];
    logic [PERM_W-1:0] r;
    r = '0;
    for (int j = 0; j < MAX_POINTS; j++) inv[j] = '0;
    for (int i = 0; i < eff_deg(); i++) inv[p[4*i +: 4]] = 4'(i);
    for (int i = 0; i < eff_deg(); i++) r[4*i +: 4] = inv[i];
    return r;
  endfunction

  function automatic int unsigned quot(input int unsigned x, input int unsigned y);
    logic [PERM_W-1:0] a, yi, r;
    a = rows[x % MAX_ORDER];
    yi = inv_perm(rows[y % MAX_ORDER]);
    r = '0;
    for (int i = 0; i < eff_deg(); i++) r[4*i +: 4] = a[4*yi[4*i +: 4] +: 4];
    return find_row(r);
  endfunction

  // point i maps to (i + k) mod n below n, fixed above
  function automatic logic [PERM_W-1:0] rot(input int unsigned n, input int unsigned k);
    logic [PERM_W-1:0] r;
    for (int unsigned i = 0; i < MAX_POINTS; i++) r[4*i +: 4] = 4'(i < n ? (i + k) % n : i);
    return r;
  endfunction

  function automatic int unsigned ident();
    int unsigned g;
    g = find_row(rot(1, 0));
    return g < eff_order() ? g : MAX_ORDER;
  endfunction

  function automatic void tally(input int unsigned x, input int unsigned upto,
                                input logic [CNT_W-1:0] delta);
    int unsigned q;
    for (int unsigned k = 0; k < upto; k++) begin
      if (stk_on[k]) begin
        q = quot(x, stk[k]);
        if (q < eff_order()) diff_cnt[q] = diff_cnt[q] + delta;
        q = quot(stk[k], x);
        if (q < eff_order()) diff_cnt[q] = diff_cnt[q] + delta;
      end
    end
  endfunction

  function automatic int unsigned eff_mode();
    return mode_r == MODE_SPARE ? MODE_DS : mode_r;
  endfunction

  function automatic bit feasible(input int unsigned newest);
    int unsigned v, inv, lim, und;
    v = eff_order();
    if (eff_mode() != MODE_PDS) begin
      for (int unsigned i = 0; i < v; i++) begin
        if (i == id_idx) continue;
        if (eff_mode() == MODE_RDS && forbidden[i]) begin
          if (diff_cnt[i] != 0) return 0;
        end else if (diff_cnt[i] > lam_r) return 0;
      end
      return 1;
    end
    if (id_idx < v && chosen[id_idx]) return 0;
    for (int unsigned k = 0; k < depth; k++) begin
      if (!stk_on[k]) continue;
      inv = find_row(inv_perm(rows[stk[k]]));
      if (inv < v && inv < newest && !chosen[inv]) return 0;
    end
    und = lam_r > mu_r ? lam_r : mu_r;
    for (int unsigned i = 0; i < v; i++) begin
      if (i == id_idx) continue;
      lim = chosen[i] ? lam_r : (i < newest ? mu_r : und);
      if (diff_cnt[i] > lim) return 0;
    end
    return 1;
  endfunction

  function automatic bit satisfied();
    int unsigned v, inv, want;
    v = eff_order();
    if (eff_mode() != MODE_PDS) begin
      for (int unsigned i = 0; i < v; i++) begin
        if (i == id_idx) continue;
        want = (eff_mode() == MODE_RDS && forbidden[i]) ? 0 : lam_r;
        if (diff_cnt[i] != want) return 0;
      end
      return 1;
    end
    if (id_idx < v && chosen[id_idx]) return 0;
    for (int unsigned k = 0; k < depth; k++) begin
      if (!stk_on[k]) continue;
      inv = find_row(inv_perm(rows[stk[k]]));
      if (inv >= v || !chosen[inv]) return 0;
    end
    for (int unsigned i = 0; i < v; i++) begin
      if (i == id_idx) continue;
      if (diff_cnt[i] != (chosen[i] ? lam_r : mu_r)) return 0;
    end
    return 1;
  endfunction

  function automatic result_t checker_step(input logic [OP_W-1:0] op,
                                           input logic [PERM_W-1:0] p,
                                           input logic [IDX_W-1:0] slot);
    result_t r;
    int unsigned x, v, top;
    r = '0;
    case (op)
      OP_LOAD: if (depth == 0) rows[slot] = p;
      OP_MARK: forbidden[slot] = 1;
      OP_PUSH: begin
        v = eff_order();
        x = find_row(p);
        id_idx = ident();
        r.index = ORD_W'(x);
        if (depth < MAX_ORDER) begin
          if (x >= v) begin
            bad_flag = 1;
            stk_on[depth] = 0;
            stk[depth] = '0;
            depth++;
          end else begin
            r.found = 1;
            tally(x, depth, CNT_W'(1));
            stk[depth] = IDX_W'(x);
            stk_on[depth] = 1;
            depth++;
            chosen[x] = 1;
            r.possible = feasible(x);
          end
        end else r.found = x < v;
      end
      OP_POP: begin
        if (depth > 0) begin
          top = depth - 1;
          if (stk_on[top]) begin
            tally(stk[top], top, '1);
            chosen[stk[top]] = 0;
          end
          stk_on[top] = 0;
          depth = top;
        end
      end
      OP_FINISH: begin
        id_idx = ident();
        r.verdict = satisfied();
      end
      default: ;
    endcase
    r.bad = bad_flag;
    return r;
  endfunction

  task automatic report(input string field, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // result checking
  result_t head;
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) report("unexpected transfer", 1, 0);
      else begin
        head = pending_results.pop_front();
        if (rsp.hit_index !== head.index) report("hit_index", rsp.hit_index, head.index);
        if (rsp.found !== head.found) report("found", rsp.found, head.found);
        if (rsp.still_possible !== head.possible)
          report("still_possible", rsp.still_possible, head.possible);
        if (rsp.verdict !== head.verdict) report("verdict", rsp.verdict, head.verdict);
        if (rsp.bad_row_seen !== head.bad) report("bad_row_seen", rsp.bad_row_seen, head.bad);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) rsp.ready <= 1'b0;
    else rsp.ready <= $urandom_range(99) >= out_idle;
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [PERM_W-1:0] p,
                      input int unsigned slot, input bit typed = 0,
                      input result_t want = '0);
    result_t r;
    while ($urandom_range(99) < in_idle) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.permutation <= p;
    req.element_slot <= IDX_W'(slot);
    r = checker_step(op, p, IDX_W'(slot));
    pending_results.insert(pending_results.size(), typed ? want : r);
    items_sent++;
    in_idle = (items_sent >= 250 && items_sent < 350) ? 0 : 19;
    out_idle = in_idle;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic quiesce();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic setreg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    case (idx)
      REG_CHECK_MODE:  mode_r = val & 3;
      REG_LAMBDA:      lam_r = val & 127;
      REG_MU:          mu_r = val & 127;
      REG_GROUP_ORDER: order_r = val & 127;
      REG_DEGREE:      deg_r = val & 31;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [PERM_W-1:0] rand_perm();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_count();
    case ($urandom_range(5))
      0: return 0;
      1: return 64;
      2: return 127;
      default: return $urandom_range(4);
    endcase
  endfunction

  stim_row_t directed_rows[$];

  function automatic void add_row(input logic [OP_W-1:0] op, input logic [PERM_W-1:0] perm,
                                  input int unsigned slot, input bit typed,
                                  input result_t want);
    stim_row_t row;
    row.op = op;
    row.perm = perm;
    row.slot = IDX_W'(slot);
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  initial begin
    int unsigned n, kind, ops, r, k, tmp;
    int unsigned members[$];
    logic [PERM_W-1:0] p;

    req.valid <= 1'b0;
    req.opcode <= OP_LOAD;
    req.permutation <= '0;
    req.element_slot <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    in_idle = 19;
    out_idle = 19;
    mode_r = MODE_DS; lam_r = 0; mu_r = 0; order_r = MAX_ORDER; deg_r = MAX_POINTS;
    for (int i = 0; i < MAX_ORDER; i++) begin
      rows[i] = '0; forbidden[i] = 0; diff_cnt[i] = '0; chosen[i] = 0;
      stk[i] = '0; stk_on[i] = 0;
    end
    depth = 0; id_idx = MAX_ORDER; bad_flag = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cyclic group of order 7 with the quadratic residue difference set
    setreg(REG_CHECK_MODE, MODE_DS);
    setreg(REG_LAMBDA, 1);
    setreg(REG_GROUP_ORDER, 7);
    setreg(REG_DEGREE, 7);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < 7; i++) add_row(OP_LOAD, rot(7, i), i, 1, '0);
    add_row(OP_PUSH, rot(7, 1), 0, 0, '0);
    add_row(OP_PUSH, rot(7, 2), 0, 0, '0);
    add_row(OP_PUSH, rot(7, 4), 0, 0, '0);
    add_row(OP_FINISH, '0, 0, 1, '{0, 0, 0, 1, 0});
    add_row(OP_PUSH, '1, 0, 1, '{7, 0, 0, 0, 1});
    for (int i = 0; i < 5; i++) add_row(OP_POP, '0, 0, 1, '{0, 0, 0, 0, 1});
    add_row(OP_MARK, '0, 63, 1, '{0, 0, 0, 0, 1});
    add_row(OP_LOAD, '1, 63, 1, '{0, 0, 0, 0, 1});
    add_row(OP_SPARE5, '1, 63, 1, '{0, 0, 0, 0, 1});
    add_row(OP_SPARE7, '1, 63, 1, '{0, 0, 0, 0, 1});
    add_row(OP_FINISH, '0, 0, 0, '0);
    foreach (directed_rows[i])
      send(directed_rows[i].op, directed_rows[i].perm, directed_rows[i].slot,
           directed_rows[i].typed, directed_rows[i].want);

    // every store entry written before any large group order
    for (int i = 0; i < MAX_ORDER; i++) send(OP_LOAD, rand_perm(), i);

    // full stack with a one element group
    quiesce();
    setreg(REG_GROUP_ORDER, 1);
    setreg(REG_DEGREE, 16);
    cfg_we_i <= 1'b0;
    send(OP_LOAD, rot(1, 0), 0);
    for (int i = 0; i < MAX_ORDER + 2; i++) send(OP_PUSH, rot(1, 0), 0);
    send(OP_FINISH, '0, 0);
    for (int i = 0; i < MAX_ORDER + 1; i++) send(OP_POP, '0, 0);

    while (items_sent < 650) begin
      while (depth > 0) send(OP_POP, rand_perm(), $urandom);
      kind = $urandom_range(7);
      members.delete();
      quiesce();
      case (kind)
        0: begin
          n = 7; members = '{1, 2, 4};
          setreg(REG_CHECK_MODE, MODE_DS); setreg(REG_LAMBDA, 1);
        end
        1: begin
          n = 13; members = '{0, 1, 3, 9};
          setreg(REG_CHECK_MODE, MODE_DS); setreg(REG_LAMBDA, 1);
        end
        2: begin
          n = 4; members = '{0, 1};
          setreg(REG_CHECK_MODE, MODE_RDS); setreg(REG_LAMBDA, 1);
        end
        3: begin
          n = 5; members = '{1, 4};
          setreg(REG_CHECK_MODE, MODE_PDS); setreg(REG_LAMBDA, 0); setreg(REG_MU, 1);
        end
        4: begin
          n = 13; members = '{1, 3, 4, 9, 10, 12};
          setreg(REG_CHECK_MODE, MODE_PDS); setreg(REG_LAMBDA, 2); setreg(REG_MU, 3);
        end
        default: begin
          n = ($urandom_range(5) == 0) ? 16 : $urandom_range(2, 9);
          setreg(REG_CHECK_MODE, $urandom_range(3));
          setreg(REG_LAMBDA, pick_count());
          setreg(REG_MU, pick_count());
        end
      endcase
      if (kind < 5 || $urandom_range(4) != 0) setreg(REG_GROUP_ORDER, n);
      else setreg(REG_GROUP_ORDER, ($urandom_range(1)) ? $urandom_range(127) : 0);
      if (kind < 5 || $urandom_range(4) != 0) setreg(REG_DEGREE, n);
      else setreg(REG_DEGREE, ($urandom_range(1)) ? $urandom_range(31) : 0);
      cfg_we_i <= 1'b0;
      for (int i = 0; i < n; i++) send(OP_LOAD, rot(n, i), i);
      if (kind == 2) send(OP_MARK, rand_perm(), 2);

      if (members.size() != 0) begin
        for (int i = members.size() - 1; i > 0; i--) begin
          k = $urandom_range(i);
          tmp = members[i]; members[i] = members[k]; members[k] = tmp;
        end
        foreach (members[i]) send(OP_PUSH, rot(n, members[i]), $urandom);
        if ($urandom_range(3) == 0) send(OP_PUSH, rot(n, $urandom_range(n - 1)), $urandom);
        send(OP_FINISH, rand_perm(), $urandom);
      end

      ops = $urandom_range(10, 30);
      for (int i = 0; i < ops; i++) begin
        r = $urandom_range(99);
        if (r < 50 && depth >= STACK_CAP) r = 60;
        if (r < 50) begin
          if ($urandom_range(4) != 0) begin
            p = rot(n, $urandom_range(n - 1));
            if ($urandom_range(1)) p = p ^ (rand_perm() & ~deg_mask(n));
          end else p = rand_perm();
          send(OP_PUSH, p, $urandom);
        end else if (r < 70) send(OP_POP, rand_perm(), $urandom);
        else if (r < 82) send(OP_FINISH, rand_perm(), $urandom);
        else if (r < 88) send(OP_MARK, rand_perm(), $urandom_range(4, 63));
        else if (r < 94) send(OP_LOAD, rand_perm(), $urandom_range(n, 63));
        else begin
          case ($urandom_range(2))
            0: send(OP_SPARE5, rand_perm(), $urandom);
            1: send(OP_SPARE6, rand_perm(), $urandom);
            default: send(OP_SPARE7, rand_perm(), $urandom);
          endcase
        end
      end
    end

    quiesce();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
